// ===== rtl/bre_pkg.sv =====
// Package for the bitmap range engine: request mode codes, stream word layout,
// default sizes and the command struct shared by the top level and the word unit.
// No dependencies.
package bre_pkg;

  localparam int NBITS_DEF     = 1024;
  localparam int WORD_BITS_DEF = 32;

  localparam int MODE_W = 3;
  localparam int POS_W  = 10;
  localparam int LEN_W  = 11;
  localparam int IN_W   = 24;
  localparam int OUT_W  = 16;

  localparam logic [LEN_W-1:0] LEN_RST = 11'd1024;

  localparam logic [MODE_W-1:0] MODE_GET = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SET = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CLR = 3'd3;
  localparam logic [MODE_W-1:0] MODE_INV = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CNT = 3'd5;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              bit_value;
  } bre_cmd_t;

endpackage

// ===== rtl/bre_word_unit.sv =====
// Shared word unit of the bitmap range engine: builds the in-range mask for one
// stored word, applies the request to it and counts the selected set bits.
// Depends on bre_pkg.
module bre_word_unit import bre_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  bre_cmd_t                       cmd_i,
  input  logic [WORD_BITS-1:0]           rdata_i,
  input  logic [$clog2(WORD_BITS)-1:0]   lo_off_i,
  input  logic [$clog2(WORD_BITS)-1:0]   hi_off_i,
  output logic [WORD_BITS-1:0]           wdata_o,
  output logic                           wen_o,
  output logic                           hit_o,
  output logic [$clog2(WORD_BITS):0]     pop_o
);

  localparam int WLG = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] ones;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] sel;

  assign ones = '1;
  // ~hi_off == WORD_BITS-1-hi_off for power-of-two word sizes
  assign mask = (ones << lo_off_i) & (ones >> (~hi_off_i));
  assign sel  = rdata_i & mask;
  assign hit_o = |sel;

  always_comb begin
    pop_o = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      pop_o = pop_o + (WLG+1)'(sel[i]);
    end
  end

  always_comb begin
    wdata_o = rdata_i;
    wen_o   = 1'b0;
    unique case (cmd_i.mode)
      MODE_PUT: begin
        wen_o   = 1'b1;
        wdata_o = cmd_i.bit_value ? (rdata_i | mask) : (rdata_i & ~mask);
      end
      MODE_SET: begin
        wen_o   = 1'b1;
        wdata_o = rdata_i | mask;
      end
      MODE_CLR: begin
        wen_o   = 1'b1;
        wdata_o = rdata_i & ~mask;
      end
      MODE_INV: begin
        wen_o   = 1'b1;
        wdata_o = rdata_i ^ mask;
      end
      default: begin
        wen_o   = 1'b0;
        wdata_o = rdata_i;
      end
    endcase
  end

endmodule

// ===== rtl/bitmap_range_engine.sv =====
// Bitmap range engine top level: request sequencer, word store, length register
// and output register. Depends on bre_pkg and bre_word_unit.
//
// A bitmap of NBITS bits kept as NBITS/WORD_BITS words (WORD_BITS a power of
// two) in a single-port-write, registered-read memory. After reset a clearing
// pass zeroes one word per cycle, all NWORDS words, before the first request is
// taken. One request runs at a time; the word unit handles one stored word per
// cycle with the read of the next word overlapped. Get and put walk one word;
// set, clear and invert walk the words spanned; count walks the words up to the
// length in use. Refused requests and count at zero length skip the walk. The
// result sits in an output register, so the next request is accepted while it
// waits.
module bitmap_range_engine import bre_pkg::*; #(
  parameter int NBITS     = NBITS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [LEN_W-1:0]  cfg_wdata_i,   // length_in_use
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_W-1:0]   s_axis_tdata,  // mode[2:0], position_low[12:3],
                                           // position_high[22:13], bit_value[23]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_W-1:0]  m_axis_tdata   // bit_out[0], set_count[11:1], error[12]
);

  localparam int NWORDS = (NBITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int WLG    = $clog2(WORD_BITS);
  localparam int CW     = (((AW + WLG) > LEN_W) ? (AW + WLG) : LEN_W) + 1;
  localparam int LEN_MAX = (1 << LEN_W) - 1;
  localparam int NB_CAP = (NBITS < LEN_MAX) ? NBITS : LEN_MAX;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [LEN_W-1:0]     len_q;
  logic [LEN_W-1:0]     len_eff;
  bre_cmd_t             cmd_q, cmd_d;
  logic [LEN_W-1:0]     lo_q, lo_d, hi_q, hi_d;
  logic [AW-1:0]        rd_ptr_q, rd_ptr_d, hi_w_q, hi_w_d, wptr_q, wptr_d;
  logic [AW-1:0]        clr_ptr_q, clr_ptr_d;
  logic                 iss_done_q, iss_done_d, vld_q, vld_d;
  logic                 bit_q, bit_d, err_q, err_d;
  logic [LEN_W-1:0]     cnt_q, cnt_d;
  logic                 out_vld_q, out_vld_d;
  logic [OUT_W-1:0]     out_data_q, out_data_d;

  logic [WORD_BITS-1:0] mem_q [NWORDS];
  logic [WORD_BITS-1:0] rdata_q;
  logic                 we, re;
  logic [AW-1:0]        wa, ra;
  logic [WORD_BITS-1:0] wd;

  logic [MODE_W-1:0]    in_mode;
  logic [LEN_W-1:0]     in_lo, in_hi;
  logic                 in_bv;
  logic                 acc;
  logic                 acc_err, acc_skip;
  logic [LEN_W-1:0]     acc_lo, acc_hi;
  logic [LEN_W-1:0]     lo_sh, hi_sh;

  logic [CW-1:0]        base, lo_c, hi_c, lo_rel, hi_rel;
  logic [WLG-1:0]       lo_off, hi_off;
  logic [WORD_BITS-1:0] u_wdata;
  logic                 u_wen, u_hit;
  logic [WLG:0]         u_pop;

  assign in_mode = s_axis_tdata[2:0];
  assign in_lo   = {1'b0, s_axis_tdata[12:3]};
  assign in_hi   = {1'b0, s_axis_tdata[22:13]};
  assign in_bv   = s_axis_tdata[23];

  assign len_eff = (len_q < LEN_W'(NB_CAP)) ? len_q : LEN_W'(NB_CAP);
  assign s_axis_tready = (state_q == S_IDLE);
  assign acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    acc_err  = 1'b0;
    acc_skip = 1'b0;
    acc_lo   = in_lo;
    acc_hi   = in_hi;
    unique case (in_mode)
      MODE_GET, MODE_PUT: begin
        acc_hi  = in_lo;
        acc_err = (in_lo >= len_eff);
      end
      MODE_SET, MODE_CLR, MODE_INV: begin
        acc_err = (in_hi >= len_eff) || (in_lo > in_hi);
      end
      MODE_CNT: begin
        acc_lo   = '0;
        acc_hi   = len_eff - LEN_W'(1);
        acc_skip = (len_eff == '0);
      end
      default: acc_err = 1'b1;
    endcase
  end

  assign lo_sh = acc_lo >> WLG;
  assign hi_sh = acc_hi >> WLG;

  // mask bounds of the word held in rdata_q
  assign base   = CW'(wptr_q) << WLG;
  assign lo_c   = CW'(lo_q);
  assign hi_c   = CW'(hi_q);
  assign lo_rel = lo_c - base;
  assign hi_rel = hi_c - base;
  assign lo_off = (lo_c > base) ? lo_rel[WLG-1:0] : '0;
  assign hi_off = (hi_c < base + CW'(WORD_BITS - 1)) ? hi_rel[WLG-1:0] : '1;

  bre_word_unit #(
    .WORD_BITS (WORD_BITS)
  ) u_word (
    .cmd_i    (cmd_q),
    .rdata_i  (rdata_q),
    .lo_off_i (lo_off),
    .hi_off_i (hi_off),
    .wdata_o  (u_wdata),
    .wen_o    (u_wen),
    .hit_o    (u_hit),
    .pop_o    (u_pop)
  );

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    rd_ptr_d   = rd_ptr_q;
    hi_w_d     = hi_w_q;
    wptr_d     = wptr_q;
    clr_ptr_d  = clr_ptr_q;
    iss_done_d = iss_done_q;
    vld_d      = 1'b0;
    bit_d      = bit_q;
    err_d      = err_q;
    cnt_d      = cnt_q;
    out_vld_d  = out_vld_q;
    out_data_d = out_data_q;
    we = 1'b0;
    wa = wptr_q;
    wd = u_wdata;
    re = 1'b0;
    ra = rd_ptr_q;

    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        we = 1'b1;
        wa = clr_ptr_q;
        wd = '0;
        clr_ptr_d = clr_ptr_q + AW'(1);
        if (clr_ptr_q == AW'(NWORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc) begin
          cmd_d.mode      = in_mode;
          cmd_d.bit_value = in_bv;
          lo_d       = acc_lo;
          hi_d       = acc_hi;
          rd_ptr_d   = AW'(lo_sh);
          hi_w_d     = AW'(hi_sh);
          iss_done_d = 1'b0;
          bit_d      = 1'b0;
          cnt_d      = '0;
          err_d      = acc_err;
          state_d    = (acc_err || acc_skip) ? S_DONE : S_WALK;
        end
      end
      S_WALK: begin
        if (!iss_done_q) begin
          re     = 1'b1;
          vld_d  = 1'b1;
          wptr_d = rd_ptr_q;
          if (rd_ptr_q == hi_w_q) begin
            iss_done_d = 1'b1;
          end else begin
            rd_ptr_d = rd_ptr_q + AW'(1);
          end
        end
        if (vld_q) begin
          we = u_wen;
          if (cmd_q.mode == MODE_CNT) begin
            cnt_d = cnt_q + LEN_W'(u_pop);
          end
          if (cmd_q.mode == MODE_GET || cmd_q.mode == MODE_PUT) begin
            bit_d = u_hit;
          end
          if (iss_done_q) begin
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d  = 1'b1;
          out_data_d = {3'b000, err_q, cnt_q, bit_q};
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (re) begin
      rdata_q <= mem_q[ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      len_q      <= LEN_RST;
      clr_ptr_q  <= '0;
      iss_done_q <= 1'b0;
      vld_q      <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_ptr_q  <= clr_ptr_d;
      iss_done_q <= iss_done_d;
      vld_q      <= vld_d;
      out_vld_q  <= out_vld_d;
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    rd_ptr_q   <= rd_ptr_d;
    hi_w_q     <= hi_w_d;
    wptr_q     <= wptr_d;
    bit_q      <= bit_d;
    err_q      <= err_d;
    cnt_q      <= cnt_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE) |-> !we)
    else $error("store written outside walk or clear");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[12] |-> (m_axis_tdata[11:0] == 12'd0))
    else $error("refused word carries data");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> (cnt_q <= len_eff))
    else $error("count exceeds length in use");

  a_vld_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> (state_q == S_WALK))
    else $error("read data pending outside walk");

endmodule

// ===== bench/bre_checker.sv =====
// Checker for the bitmap range engine: watches the config port and both stream
// channels, keeps its own copy of the bitmap and length, and compares result words.
// Depends on bre_pkg.
`timescale 1ns / 100ps

module bre_checker import bre_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i,
  input  logic             s_valid_i,
  input  logic             s_ready_i,
  input  logic [IN_W-1:0]  s_data_i,    // mode[2:0], position_low[12:3],
                                        // position_high[22:13], bit_value[23]
  input  logic             m_valid_i,
  input  logic             m_ready_i,
  input  logic [OUT_W-1:0] m_data_i,    // bit_out[0], set_count[11:1], error[12]
  output int               mismatches_o,
  output int               awaited_o
);

  typedef struct packed {
    logic             bit_out;
    logic [LEN_W-1:0] set_count;
    logic             error;
  } bre_result_t;

  bre_result_t          awaited_q[$];
  bre_result_t          want;
  logic [NBITS_DEF-1:0] bitmap;
  logic [LEN_W-1:0]     length_reg;
  int                   mismatch_total = 0;

  assign mismatches_o = mismatch_total;

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned exp_v);
    $display("%0t bitmap check: %s got %0d, expected %0d", $time, field, got, exp_v);
    mismatch_total++;
  endtask

  // Applies one request word to the bitmap copy and returns its result word.
  function automatic bre_result_t service_request(input logic [IN_W-1:0] w);
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  lo;
    logic [POS_W-1:0]  hi;
    logic              bv;
    int unsigned       eff_len;
    int unsigned       p;
    bre_result_t       r;
    mode    = w[2:0];
    lo      = w[12:3];
    hi      = w[22:13];
    bv      = w[23];
    eff_len = (length_reg > NBITS_DEF) ? NBITS_DEF : 32'(length_reg);
    r       = '0;
    case (mode)
      MODE_GET, MODE_PUT: begin
        if (lo >= eff_len) begin
          r.error = 1'b1;
        end else begin
          r.bit_out = bitmap[lo];
          if (mode == MODE_PUT) bitmap[lo] = bv;
        end
      end
      MODE_SET, MODE_CLR, MODE_INV: begin
        if (hi >= eff_len || lo > hi) begin
          r.error = 1'b1;
        end else begin
          for (p = 32'(lo); p <= hi; p++) begin
            if (mode == MODE_SET) bitmap[p] = 1'b1;
            else if (mode == MODE_CLR) bitmap[p] = 1'b0;
            else bitmap[p] = ~bitmap[p];
          end
        end
      end
      MODE_CNT: begin
        for (p = 0; p < eff_len; p++) r.set_count += bitmap[p];
      end
      default: begin
        r.error = 1'b1;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bitmap     = '0;
      length_reg = LEN_RST;
      awaited_q.delete();
      awaited_o <= 0;
    end else begin
      if (m_valid_i && m_ready_i) begin
        if (awaited_q.size() == 0) begin
          report_mismatch("result word with nothing pending", 32'(m_data_i), 0);
        end else begin
          want = awaited_q.pop_front();
          if (m_data_i[0] !== want.bit_out)
            report_mismatch("bit_out", 32'(m_data_i[0]), 32'(want.bit_out));
          if (m_data_i[11:1] !== want.set_count)
            report_mismatch("set_count", 32'(m_data_i[11:1]), 32'(want.set_count));
          if (m_data_i[12] !== want.error)
            report_mismatch("error", 32'(m_data_i[12]), 32'(want.error));
        end
      end
      if (cfg_we_i) length_reg = cfg_wdata_i;
      if (s_valid_i && s_ready_i) awaited_q.push_back(service_request(s_data_i));
      awaited_o <= awaited_q.size();
    end
  end

endmodule

// ===== bench/tb_bitmap_range_engine.sv =====
// Testbench top for the bitmap range engine: clock, reset, length writes, request
// stimulus and result back-pressure; checking is done in bre_checker.
// Depends on bre_pkg, bre_checker and bitmap_range_engine.
`timescale 1ns / 100ps

module tb_bitmap_range_engine;
  import bre_pkg::*;

  localparam int LIMIT       = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(NBITS_DEF - 1);

  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_we_i      = 1'b0;
  logic [LEN_W-1:0] cfg_wdata_i   = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  int          mismatches;
  int          awaited;
  int          cycles       = 0;
  int          hold_asks    = 0;
  int          holds_served = 0;
  logic        calm         = 1'b0;
  int unsigned cur_len      = NBITS_DEF;

  int unsigned phase_len [6] = '{2047, 1024, 33, 1, 512, 1000};
  int unsigned phase_cnt [6] = '{60, 200, 50, 30, 60, 50};

  always #1 clk_i = ~clk_i;

  bitmap_range_engine i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  bre_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_i    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .m_valid_i    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_i     (m_axis_tdata),
    .mismatches_o (mismatches),
    .awaited_o    (awaited)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: random back-pressure, long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_asks != holds_served) begin
        holds_served++;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 19);
      end
    end
  end

  function automatic logic [IN_W-1:0] make_word(input logic [MODE_W-1:0] mode,
                                                input logic [POS_W-1:0] lo,
                                                input logic [POS_W-1:0] hi,
                                                input logic bv);
    return {bv, hi, lo, mode};
  endfunction

  task automatic send_word(input logic [IN_W-1:0] w);
    int unsigned gap;
    if (!calm && $urandom_range(99) < 19) begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(4, 40) : $urandom_range(1, 3);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= w;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (awaited != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_length(input int unsigned len);
    drain();
    cfg_wdata_i <= len[LEN_W-1:0];
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_len      = (len > NBITS_DEF) ? NBITS_DEF : len;
  endtask

  // mostly in-range positions and short spans, some full spans and raw noise
  task automatic random_request();
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  lo;
    logic [POS_W-1:0]  hi;
    int unsigned       pick;
    int unsigned       span;
    pick = $urandom_range(99);
    if (pick < 20) mode = MODE_GET;
    else if (pick < 38) mode = MODE_PUT;
    else if (pick < 52) mode = MODE_SET;
    else if (pick < 64) mode = MODE_CLR;
    else if (pick < 76) mode = MODE_INV;
    else if (pick < 92) mode = MODE_CNT;
    else mode = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
    lo = POS_W'($urandom);
    hi = POS_W'($urandom);
    if (cur_len != 0 && $urandom_range(99) < 88) begin
      if ($urandom_range(19) == 0) begin
        lo = '0;
        hi = POS_W'(cur_len - 1);
      end else begin
        lo   = POS_W'($urandom_range(0, cur_len - 1));
        span = ($urandom_range(9) == 0) ? cur_len : $urandom_range(0, 40);
        hi   = (lo + span >= cur_len) ? POS_W'(cur_len - 1) : POS_W'(lo + span);
      end
    end
    send_word(make_word(mode, lo, hi, 1'($urandom_range(1))));
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    set_length(1024);
    send_word(make_word(MODE_GET, 0, 0, 1'b0));
    send_word(make_word(MODE_PUT, 0, 0, 1'b1));
    send_word(make_word(MODE_GET, 0, 0, 1'b0));
    send_word(make_word(MODE_PUT, POS_MAX, 0, 1'b1));
    send_word(make_word(MODE_PUT, POS_MAX, POS_MAX, 1'b0));
    send_word(make_word(MODE_SET, 0, POS_MAX, 1'b0));
    send_word(make_word(MODE_CNT, 0, 0, 1'b0));
    send_word(make_word(MODE_CLR, 1, POS_MAX - POS_W'(1), 1'b1));
    send_word(make_word(MODE_CNT, POS_MAX, POS_MAX, 1'b1));
    send_word(make_word(MODE_INV, 0, POS_MAX, 1'b0));
    send_word(make_word(MODE_CNT, 0, 0, 1'b0));
    send_word(make_word(MODE_SET, POS_MAX, POS_MAX, 1'b0));
    send_word(make_word(MODE_INV, 31, 32, 1'b0));
    send_word(make_word(MODE_CLR, 700, 699, 1'b0));
    send_word(make_word(MODE_GET, POS_MAX, 0, 1'b1));
    send_word(make_word(MODE_SPARE_LO, POS_MAX, POS_MAX, 1'b1));
    send_word(make_word(MODE_SPARE_HI, 0, 0, 1'b0));
    send_word(make_word(MODE_CNT, 0, 0, 1'b0));

    // shortened length: addressing past it, and stale bits above it
    set_length(40);
    send_word(make_word(MODE_GET, 40, 0, 1'b0));
    send_word(make_word(MODE_PUT, 39, 0, 1'b1));
    send_word(make_word(MODE_SET, 30, 40, 1'b0));
    send_word(make_word(MODE_CLR, 0, 39, 1'b0));
    send_word(make_word(MODE_CNT, 0, 0, 1'b0));

    set_length(0);
    send_word(make_word(MODE_GET, 0, 0, 1'b0));
    send_word(make_word(MODE_PUT, 0, 0, 1'b1));
    send_word(make_word(MODE_SET, 0, 0, 1'b0));
    send_word(make_word(MODE_CNT, 0, 0, 1'b0));

    for (int ph = 0; ph < 6; ph++) begin
      set_length(phase_len[ph]);
      for (int n = 0; n < phase_cnt[ph]; n++) begin
        if (ph == 1) begin
          if (n == 40) hold_asks <= hold_asks + 1;
          if (n == 70) drain();
          if (n == 100) calm <= 1'b1;
          if (n == 180) calm <= 1'b0;
        end
        random_request();
      end
    end

    drain();
    repeat (40) @(negedge clk_i);
    if (mismatches == 0 && awaited == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
